// ----- rtl/core/rxas_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rxas_pkg
// Shared types and constants for the repeating-key XOR letter scorer.
// ----------------------------------------------------------------------------
package rxas_pkg;

  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int KEY_WORD_W = 32;
  localparam int KEY_LEN_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  // effective key length can reach 7
  localparam int LEN_W      = 4;
  // wide enough for count * 10
  localparam int PROD_W     = COUNT_W + 4;
  localparam int KEY_BYTES  = KEY_WORD_W / BYTE_W;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [PROD_W-1:0]  prod_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
           ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
  endfunction

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage : rxas_pkg
`default_nettype wire

// ----- rtl/core/repeating_xor_alpha_scorer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// repeating_xor_alpha_scorer
// XOR-decodes a ciphertext byte stream with a repeating key and scores it.
// ----------------------------------------------------------------------------
// One byte is taken per clock. Each byte is XORed with the key byte at the
// rotating key position, counted, and checked for an ASCII letter; the byte
// flagged last_byte closes the pass and produces one result carrying both
// saturating counts and the accepted flag (letters * 10 > bytes * 9). Its
// result is registered first in the pending stage and then, after the
// compare, in the output register. Non-last bytes are never held up; a last
// byte waits only while a previous result still fills both result stages.
module repeating_xor_alpha_scorer
  import rxas_pkg::*;
#(
  parameter int MAX_KEY_LEN = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [BYTE_W-1:0]     cipher_byte,
  input  wire logic                  last_byte,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic                  accepted,
  output      logic [COUNT_W-1:0]    letter_count,
  output      logic [COUNT_W-1:0]    total_count
);

  localparam int POS_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  logic [KEY_WORD_W-1:0] key_word;
  logic [KEY_LEN_W-1:0]  key_length;
  logic [POS_W-1:0]      key_position;
  logic [POS_W-1:0]      key_position_next;
  count_t                letters_seen;
  count_t                letters_next;
  count_t                bytes_seen;
  count_t                bytes_next;

  logic                  pend_valid;
  count_t                pend_letters;
  count_t                pend_bytes;

  logic [LEN_W-1:0]      eff_len;
  logic [POS_W-1:0]      pos_use;
  logic [LEN_W-1:0]      pos_inc;
  logic [BYTE_W-1:0]     key_byte;
  logic [BYTE_W-1:0]     plain;
  logic                  in_take;
  logic                  pend_move;
  prod_t                 letters_x10;
  prod_t                 bytes_x9;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word   <= '0;
      key_length <= KEY_LEN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_WORD:   key_word   <= cfg_data[KEY_WORD_W-1:0];
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective key length, clamped to 1..MAX_KEY_LEN
  always_comb begin
    eff_len = {1'b0, key_length};
    if (eff_len == '0) begin
      eff_len = LEN_W'(1);
    end
    if (eff_len > LEN_W'(MAX_KEY_LEN)) begin
      eff_len = LEN_W'(MAX_KEY_LEN);
    end
  end

  // key byte select and decode
  always_comb begin
    pos_use = key_position;
    if (LEN_W'(key_position) >= eff_len) begin
      pos_use = '0;
    end
    key_byte = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (int'(pos_use) == i) begin
        key_byte = key_word[BYTE_W*i +: BYTE_W];
      end
    end
    plain   = cipher_byte ^ key_byte;
    pos_inc = LEN_W'(pos_use) + LEN_W'(1);
    key_position_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
    letters_next = is_letter(plain) ? sat_inc(letters_seen) : letters_seen;
    bytes_next   = sat_inc(bytes_seen);
  end

  // handshake
  assign pend_move = pend_valid && (!out_valid || !out_stall);
  assign in_stall  = last_byte && pend_valid && !pend_move;
  assign in_take   = in_valid && !in_stall;

  // running counts and key position
  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      letters_seen <= '0;
      bytes_seen   <= '0;
    end else if (in_take) begin
      if (last_byte) begin
        key_position <= '0;
        letters_seen <= '0;
        bytes_seen   <= '0;
      end else begin
        key_position <= key_position_next;
        letters_seen <= letters_next;
        bytes_seen   <= bytes_next;
      end
    end
  end

  // finished pass waiting for the compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_take && last_byte) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && last_byte) begin
      pend_letters <= letters_next;
      pend_bytes   <= bytes_next;
    end
  end

  // letters * 10 against bytes * 9
  assign letters_x10 = (prod_t'(pend_letters) << 3) + (prod_t'(pend_letters) << 1);
  assign bytes_x9    = (prod_t'(pend_bytes) << 3) + prod_t'(pend_bytes);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      accepted     <= (letters_x10 > bytes_x9);
      letter_count <= pend_letters;
      total_count  <= pend_bytes;
    end
  end

endmodule : repeating_xor_alpha_scorer
`default_nettype wire

// ----- test/rxas_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxas_checker
// Watches the key register writes and both handshake channels of the scorer,
// decodes every accepted ciphertext byte with its own copy of the key state,
// queues the score that each closing byte must produce and compares every
// accepted result with the oldest queued score, field by field.
// ----------------------------------------------------------------------------
module rxas_checker
  import rxas_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [BYTE_W-1:0]     cipher_byte,
  input  wire logic                  last_byte,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic                  accepted,
  input  wire logic [COUNT_W-1:0]    letter_count,
  input  wire logic [COUNT_W-1:0]    total_count,
  output int                         pending,
  output int                         failures,
  output int                         checked
);

  localparam int KEY_SPAN_MAX = 4;

  typedef struct packed {
    logic   accepted;
    count_t letters;
    count_t total;
  } score_t;

  logic [KEY_WORD_W-1:0] key_word = '0;
  logic [KEY_LEN_W-1:0]  key_length = 3'd1;
  int                    key_pos = 0;
  count_t                letter_tally = '0;
  count_t                byte_tally = '0;
  score_t                score_q[$];
  int                    fail_count = 0;
  int                    match_count = 0;

  assign failures = fail_count;
  assign checked  = match_count;

  initial pending = 0;

  function automatic count_t bump(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic alpha(input logic [BYTE_W-1:0] c);
    return (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z], [CHAR_UPPER_A:CHAR_UPPER_Z]});
  endfunction

  // decode one byte, advance the key position and queue a score on the closing byte
  task automatic decode_and_count(input logic [BYTE_W-1:0] c, input logic closes);
    int                span;
    int                p;
    logic [BYTE_W-1:0] plain;
    score_t            s;
    span = (key_length == 0) ? 1 :
           (key_length > KEY_SPAN_MAX) ? KEY_SPAN_MAX : int'(key_length);
    p = (key_pos >= span) ? 0 : key_pos;
    plain = c ^ ((p < KEY_BYTES) ? key_word[BYTE_W*p +: BYTE_W] : '0);
    if (alpha(plain)) letter_tally = bump(letter_tally);
    byte_tally = bump(byte_tally);
    key_pos = (p + 1 >= span) ? 0 : p + 1;
    if (closes) begin
      s.accepted = ({32'd0, letter_tally} * 64'd10) > ({32'd0, byte_tally} * 64'd9);
      s.letters  = letter_tally;
      s.total    = byte_tally;
      score_q.push_back(s);
      letter_tally = '0;
      byte_tally   = '0;
      key_pos      = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    score_t want;
    if (rst) begin
      key_word     = '0;
      key_length   = 3'd1;
      key_pos      = 0;
      letter_tally = '0;
      byte_tally   = '0;
      score_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_KEY_WORD) key_word = cfg_data[KEY_WORD_W-1:0];
        else if (cfg_index == REG_KEY_LENGTH) key_length = cfg_data[KEY_LEN_W-1:0];
      end
      if (in_valid && !in_stall) decode_and_count(cipher_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (score_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no score pending: accepted=%0b letters=%0d bytes=%0d",
                     $time, accepted, letter_count, total_count);
          fail_count++;
        end else begin
          want = score_q.pop_front();
          if (accepted !== want.accepted || letter_count !== want.letters ||
              total_count !== want.total) begin
            if (fail_count < 10)
              $display("%0t: score mismatch: expected accepted=%0b letters=%0d bytes=%0d, %s",
                       $time, want.accepted, want.letters, want.total,
                       $sformatf("got accepted=%0b letters=%0d bytes=%0d",
                                 accepted, letter_count, total_count));
            fail_count++;
          end else begin
            match_count++;
          end
        end
      end
    end
    pending <= score_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the repeating-key XOR letter scorer. Runs a short
// directed set (byte extremes, out-of-range key lengths, a key length cut
// short in mid-stream, the ninety percent boundary), then random phases of
// mostly letter-heavy encrypted streams mixed with noise and unclosed
// streams, under random source gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import rxas_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_WORD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     cipher_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  accepted;
  logic [COUNT_W-1:0]    letter_count;
  logic [COUNT_W-1:0]    total_count;
  int                    pending;
  int                    failures;
  int                    checked;

  logic [KEY_WORD_W-1:0] key_now = '0;
  int                    span_now = 1;
  bit                    tx_steady = 1'b0;
  bit                    rx_steady = 1'b0;
  int                    stall_left = 0;
  int                    sent_bytes = 0;
  int                    sent_streams = 0;
  int                    key_settings = 0;

  repeating_xor_alpha_scorer DUT (.*);
  rxas_checker score_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  function automatic logic [7:0] rand_other();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h40));
      1: return 8'($urandom_range(8'h5b, 8'h60));
      2: return 8'($urandom_range(8'h7b, 8'hff));
      default: begin
        case ($urandom_range(0, 3))
          0: return 8'h40;
          1: return 8'h5b;
          2: return 8'h60;
          default: return 8'h7b;
        endcase
      end
    endcase
  endfunction

  // result stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !rx_steady && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic closes);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cipher_byte <= b;
    last_byte   <= closes;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    if (closes) sent_streams++;
  endtask

  // stop sending and let every pending score come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_key(input logic [31:0] kw, input logic [31:0] kl);
    cfg_write <= 1'b1;
    cfg_index <= REG_KEY_WORD;
    cfg_data  <= kw;
    @(posedge clk);
    cfg_index <= REG_KEY_LENGTH;
    cfg_data  <= kl;
    @(posedge clk);
    cfg_write <= 1'b0;
    key_now = kw;
    case (kl[2:0]) inside
      3'd0: span_now = 1;
      [3'd5:3'd7]: span_now = 4;
      default: span_now = int'(kl[2:0]);
    endcase
    key_settings++;
  endtask

  // letter-heavy plaintext encrypted with the current key, or raw noise
  task automatic send_message(input int n, input bit well_formed, input bit closes);
    int          others;
    logic [7:0]  plain;
    logic [7:0]  b;
    others = $urandom_range(0, (n + 3) / 4);
    for (int i = 0; i < n; i++) begin
      if (well_formed) begin
        plain = ($urandom_range(0, n - 1) < others) ? rand_other() : rand_letter();
        b = plain ^ key_now[8 * (i % span_now) +: 8];
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b, closes && (i == n - 1));
    end
  endtask

  initial begin : stimulus
    int          n;
    int          r;
    logic [31:0] kw;
    logic [2:0]  kl;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key: byte extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7a, 1'b1);
    drain();
    // zero key length acts as one
    program_key(32'h2020_2020, 32'h0000_0000);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7a, 1'b1);
    drain();
    // length above the maximum clamps to four, position wraps on the fifth byte
    program_key(32'hffa5_5a00, 32'hffff_ffff);
    send_byte(8'h61, 1'b0);
    send_byte(8'h1b, 1'b0);
    send_byte(8'hdf, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h40, 1'b1);
    drain();
    // shorten the key while the position sits past the new length
    program_key(32'h0302_0100, 32'h0000_0004);
    send_byte(8'h41, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h45, 1'b0);
    drain();
    program_key(32'h0302_0100, 32'h0000_0002);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    drain();
    // exactly ninety percent letters is not accepted
    program_key(32'h0000_0000, 32'h0000_0001);
    for (int i = 0; i < 9; i++) send_byte(8'(8'h41 + i), 1'b0);
    send_byte(8'h5b, 1'b1);

    while (sent_bytes < 1800) begin
      drain();
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 9);
        kw = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hffff_ffff : $urandom;
        kl = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        program_key(kw, {29'($urandom), kl});
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 6)) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        r = $urandom_range(0, 9);
        send_message(n, r < 7, r != 9);
      end
    end
    drain();

    $display("scored %0d ciphertext bytes in %0d closed streams, %0d results checked",
             sent_bytes, sent_streams, checked);
    $display("%0d key settings applied, %0d failures", key_settings, failures);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rxas_pkg.sv
rtl/core/repeating_xor_alpha_scorer.sv
test/rxas_checker.sv
test/tb_top.sv
